/* hw/rtl/arpns_pkg.sv */
// Shared types and constants for the arpeggiator note stepper.
// Used by the channel interfaces and by every module of the block but the queue; depends on nothing.

package arpns_pkg;

   localparam int KIND_BITS  = 2;
   localparam int EVENT_BITS = 2;
   localparam int STYLE_BITS = 2;
   localparam int RAND_BITS  = 16;
   localparam int OP_BITS    = 2;

   localparam logic [KIND_BITS-1:0] KIND_NOTE_ON  = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_NOTE_OFF = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_CLEAR    = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_TICK     = 2'd3;

   localparam logic [EVENT_BITS-1:0] EVENT_PLAY    = 2'd0;
   localparam logic [EVENT_BITS-1:0] EVENT_ALL_OFF = 2'd1;
   localparam logic [EVENT_BITS-1:0] EVENT_DROPPED = 2'd2;

   localparam logic [STYLE_BITS-1:0] STYLE_DOWN   = 2'd1;
   localparam logic [STYLE_BITS-1:0] STYLE_RANDOM = 2'd2;

   typedef enum logic [OP_BITS-1:0] {
      OP_NOTE_ON  = 2'd0,
      OP_NOTE_OFF = 2'd1,
      OP_CLEAR    = 2'd2,
      OP_TICK     = 2'd3
   } arpns_op_type;

endpackage

/* hw/rtl/arpns_if.sv */
// Valid/ready channel interfaces for requests and results of the note stepper.
// Depends on arpns_pkg for the field widths.

interface arpns_req_if #(parameter int PITCH_BITS = 16);
   logic                                  valid;
   logic                                  ready;
   logic        [arpns_pkg::KIND_BITS-1:0] kind;
   logic signed [PITCH_BITS-1:0]          pitch;
   logic        [arpns_pkg::RAND_BITS-1:0] random_value;

   modport source (output valid, kind, pitch, random_value, input ready);
   modport sink   (input valid, kind, pitch, random_value, output ready);
endinterface

interface arpns_rsp_if #(parameter int PITCH_BITS = 16);
   logic                                   valid;
   logic                                   ready;
   logic        [arpns_pkg::EVENT_BITS-1:0] event_res;
   logic signed [PITCH_BITS-1:0]           note_pitch;

   modport source (output valid, event_res, note_pitch, input ready);
   modport sink   (input valid, event_res, note_pitch, output ready);
endinterface

/* hw/rtl/arpeggiator_note_stepper_core.sv */
// Top level of the arpeggiator note stepper: front end, command queue and execution unit.
// Depends on arpns_pkg, arpns_if, arpns_front, arpns_queue and arpns_back.
//
//   Channel   Direction  Moves
//   req_chan  in         one request: kind, pitch, random_value
//   rsp_chan  out        zero or one result per request: event_res, note_pitch
//   csr_*     in         write of the step style register
//
// A request passes the front register and then the queue. Note on, note off and clear
// are then done in the idle state of the execution unit; a step tick with notes held
// holds it through the divide and emit states, waiting on the bit-serial remainder unit.
// Reset is synchronous and empties the table, stops play and sets the style to up.
// Either side may stall: the queue keeps accepting requests while a result waits, until it is full.

module arpeggiator_note_stepper_core #(
   parameter int MAX_NOTES  = 16,
   parameter int PITCH_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   arpns_req_if.sink                         req_chan,
   arpns_rsp_if.source                       rsp_chan,
   input  logic                              csr_we,
   input  logic [arpns_pkg::STYLE_BITS-1:0]  csr_wdata
);

   localparam int CMD_BITS = arpns_pkg::OP_BITS + arpns_pkg::RAND_BITS + PITCH_BITS;

   logic                front_valid, front_ready;
   logic [CMD_BITS-1:0] front_cmd;
   logic                back_valid, back_ready;
   logic [CMD_BITS-1:0] back_cmd;

   arpns_front #(
      .PITCH_BITS (PITCH_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd       (front_cmd)
   );

   arpns_queue #(
      .WIDTH (CMD_BITS)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_cmd),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_cmd)
   );

   arpns_back #(
      .MAX_NOTES  (MAX_NOTES),
      .PITCH_BITS (PITCH_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd_valid (back_valid),
      .cmd_ready (back_ready),
      .cmd       (back_cmd),
      .rsp       (rsp_chan)
   );

endmodule

/* hw/rtl/arpns_front.sv */
// Front end: takes requests from the input channel and decodes them into commands.
// Depends on arpns_pkg and arpns_req_if.

module arpns_front #(
   parameter int PITCH_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   arpns_req_if.sink           req,
   output logic                cmd_valid,
   input  logic                cmd_ready,
   output logic [arpns_pkg::OP_BITS+arpns_pkg::RAND_BITS+PITCH_BITS-1:0] cmd
);

   localparam int CMD_BITS = arpns_pkg::OP_BITS + arpns_pkg::RAND_BITS + PITCH_BITS;

   logic                 cmd_valid_ff, cmd_valid_in;
   logic [CMD_BITS-1:0]  cmd_ff, cmd_in;
   arpns_pkg::arpns_op_type op_dec;
   logic                 take;

   assign req.ready = !cmd_valid_ff || cmd_ready;
   assign take      = req.valid && req.ready;

   always_comb begin
      case (req.kind)
         arpns_pkg::KIND_NOTE_ON:  op_dec = arpns_pkg::OP_NOTE_ON;
         arpns_pkg::KIND_NOTE_OFF: op_dec = arpns_pkg::OP_NOTE_OFF;
         arpns_pkg::KIND_CLEAR:    op_dec = arpns_pkg::OP_CLEAR;
         arpns_pkg::KIND_TICK:     op_dec = arpns_pkg::OP_TICK;
         default:                  op_dec = arpns_pkg::OP_TICK;
      endcase
   end

   always_comb begin
      cmd_valid_in = cmd_valid_ff && !cmd_ready;
      cmd_in       = cmd_ff;
      if (take) begin
         cmd_valid_in = 1'b1;
         cmd_in       = {op_dec, req.random_value, req.pitch};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
      end
      cmd_ff <= cmd_in;
   end

   assign cmd_valid = cmd_valid_ff;
   assign cmd       = cmd_ff;

endmodule

/* hw/rtl/arpns_queue.sv */
// Two-entry command queue between the front end and the execution unit.
// Depends on nothing but its width parameter.

module arpns_queue #(
   parameter int WIDTH = 34
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int DEPTH = 2;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             push, pop;

   assign push_ready = fill_ff != 2'(DEPTH);
   assign pop_valid  = fill_ff != 2'd0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* hw/rtl/arpns_modulo.sv */
// Bit-serial remainder unit: one dividend bit per cycle, restoring form.
// Depends on arpns_pkg for the dividend width.

module arpns_modulo #(
   parameter int DIVISOR_BITS = 5,
   parameter int REM_BITS     = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [arpns_pkg::RAND_BITS-1:0]  dividend,
   input  logic [DIVISOR_BITS-1:0]          divisor,
   output logic                             done,
   output logic [REM_BITS-1:0]              remainder
);

   localparam int DW     = arpns_pkg::RAND_BITS;
   localparam int STEP_W = $clog2(DW);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic [DW-1:0]           shift_ff, shift_in;
   logic [DIVISOR_BITS-1:0] rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0] divisor_ff, divisor_in;
   logic [DIVISOR_BITS:0]   trial, diff;

   assign trial = {rem_ff, shift_ff[DW-1]};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      shift_in   = shift_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         step_in    = STEP_W'(DW - 1);
         shift_in   = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         shift_in = shift_ff << 1;
         rem_in   = (trial >= {1'b0, divisor_ff}) ? diff[DIVISOR_BITS-1:0]
                                                  : trial[DIVISOR_BITS-1:0];
         step_in  = step_ff - STEP_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff    <= step_in;
      shift_ff   <= shift_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff[REM_BITS-1:0];

endmodule

/* hw/rtl/arpns_back.sv */
// Execution unit: sorted note table, play state, style register and result register.
// Depends on arpns_pkg, arpns_rsp_if and arpns_modulo.

module arpns_back #(
   parameter int MAX_NOTES  = 16,
   parameter int PITCH_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [arpns_pkg::STYLE_BITS-1:0]      csr_wdata,
   input  logic                                  cmd_valid,
   output logic                                  cmd_ready,
   input  logic [arpns_pkg::OP_BITS+arpns_pkg::RAND_BITS+PITCH_BITS-1:0] cmd,
   arpns_rsp_if.source                           rsp
);

   localparam int CMD_BITS = arpns_pkg::OP_BITS + arpns_pkg::RAND_BITS + PITCH_BITS;
   localparam int CW       = $clog2(MAX_NOTES + 1);
   localparam int IW       = $clog2(MAX_NOTES);
   localparam int RB       = arpns_pkg::RAND_BITS;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DIVIDE = 3'b010,
      ST_EMIT   = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic signed [PITCH_BITS-1:0] notes_ff [MAX_NOTES];
   logic signed [PITCH_BITS-1:0] notes_in [MAX_NOTES];
   logic signed [PITCH_BITS-1:0] ins_val  [MAX_NOTES];
   logic signed [PITCH_BITS-1:0] rem_val  [MAX_NOTES];

   logic [CW-1:0]                      count_ff, count_in;
   logic [IW-1:0]                      index_ff, index_in;
   logic                               unset_ff, unset_in;
   logic                               playing_ff, playing_in;
   logic [arpns_pkg::STYLE_BITS-1:0]   style_ff, style_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [arpns_pkg::EVENT_BITS-1:0]   rsp_event_ff, rsp_event_in;
   logic signed [PITCH_BITS-1:0]       rsp_pitch_ff, rsp_pitch_in;

   arpns_pkg::arpns_op_type      cmd_op;
   logic [RB-1:0]                cmd_rand;
   logic signed [PITCH_BITS-1:0] cmd_pitch;

   logic [MAX_NOTES-1:0] cell_valid, cell_lt, cell_eq;
   logic                 found, full, out_free;
   logic                 div_start, div_done;
   logic [RB-1:0]        div_dividend;
   logic [IW-1:0]        div_remainder;

   assign cmd_op    = arpns_pkg::arpns_op_type'(cmd[CMD_BITS-1 -: arpns_pkg::OP_BITS]);
   assign cmd_rand  = cmd[PITCH_BITS +: RB];
   assign cmd_pitch = cmd[PITCH_BITS-1:0];

   // Every table cell compares itself with the request pitch and works out
   // its own value for an insert and for a removal.
   for (genvar g = 0; g < MAX_NOTES; g++) begin : g_cell
      assign cell_valid[g] = CW'(g) < count_ff;
      assign cell_lt[g]    = cell_valid[g] && (notes_ff[g] < cmd_pitch);
      assign cell_eq[g]    = cell_valid[g] && (notes_ff[g] == cmd_pitch);
      if (g == 0) begin : g_first
         assign ins_val[g] = cell_lt[g] ? notes_ff[g] : cmd_pitch;
      end else begin : g_rest
         assign ins_val[g] = cell_lt[g]     ? notes_ff[g] :
                             cell_lt[g - 1] ? cmd_pitch   : notes_ff[g - 1];
      end
      if (g == MAX_NOTES - 1) begin : g_last
         assign rem_val[g] = notes_ff[g];
      end else begin : g_inner
         assign rem_val[g] = cell_lt[g] ? notes_ff[g] : notes_ff[g + 1];
      end
   end

   assign found     = |cell_eq;
   assign full      = count_ff == CW'(MAX_NOTES);
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign cmd_ready = (state_ff == ST_IDLE) && out_free;

   always_comb begin
      notes_in     = notes_ff;
      count_in     = count_ff;
      index_in     = index_ff;
      unset_in     = unset_ff;
      playing_in   = playing_ff;
      style_in     = csr_we ? csr_wdata : style_ff;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_event_in = rsp_event_ff;
      rsp_pitch_in = rsp_pitch_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid && out_free) begin
               case (cmd_op)
                  arpns_pkg::OP_NOTE_ON: begin
                     if (!found && full) begin
                        rsp_valid_in = 1'b1;
                        rsp_event_in = arpns_pkg::EVENT_DROPPED;
                        rsp_pitch_in = cmd_pitch;
                     end else if (!found) begin
                        notes_in   = ins_val;
                        count_in   = count_ff + CW'(1);
                        playing_in = 1'b1;
                     end
                  end
                  arpns_pkg::OP_NOTE_OFF: begin
                     if (found) begin
                        notes_in = rem_val;
                        count_in = count_ff - CW'(1);
                        if (count_ff == CW'(1) && playing_ff) begin
                           playing_in   = 1'b0;
                           index_in     = '0;
                           unset_in     = 1'b1;
                           rsp_valid_in = 1'b1;
                           rsp_event_in = arpns_pkg::EVENT_ALL_OFF;
                           rsp_pitch_in = '0;
                        end
                     end
                  end
                  arpns_pkg::OP_CLEAR: begin
                     if (count_ff != '0) begin
                        count_in     = '0;
                        playing_in   = 1'b0;
                        index_in     = '0;
                        unset_in     = 1'b1;
                        rsp_valid_in = 1'b1;
                        rsp_event_in = arpns_pkg::EVENT_ALL_OFF;
                        rsp_pitch_in = '0;
                     end
                  end
                  arpns_pkg::OP_TICK: begin
                     if (playing_ff && count_ff != '0) begin
                        div_start = 1'b1;
                        state_in  = ST_DIVIDE;
                        case (style_ff)
                           arpns_pkg::STYLE_DOWN: begin
                              div_dividend = unset_ff ? RB'(count_ff) - RB'(1)
                                 : RB'(index_ff) + RB'(count_ff) - RB'(1);
                           end
                           arpns_pkg::STYLE_RANDOM: begin
                              div_dividend = cmd_rand;
                           end
                           default: begin
                              div_dividend = unset_ff ? '0 : RB'(index_ff) + RB'(1);
                           end
                        endcase
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               index_in = div_remainder;
               unset_in = 1'b0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_event_in = arpns_pkg::EVENT_PLAY;
            rsp_pitch_in = notes_ff[index_ff];
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         index_ff     <= '0;
         unset_ff     <= 1'b1;
         playing_ff   <= 1'b0;
         style_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         index_ff     <= index_in;
         unset_ff     <= unset_in;
         playing_ff   <= playing_in;
         style_ff     <= style_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      notes_ff     <= notes_in;
      rsp_event_ff <= rsp_event_in;
      rsp_pitch_ff <= rsp_pitch_in;
   end

   arpns_modulo #(
      .DIVISOR_BITS (CW),
      .REM_BITS     (IW)
   ) u_modulo (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (count_ff),
      .done      (div_done),
      .remainder (div_remainder)
   );

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.event_res  = rsp_event_ff;
   assign rsp.note_pitch = rsp_pitch_ff;

   a_playing_tracks_count: assert property (@(posedge clock) disable iff (reset)
      playing_ff == (count_ff != '0))
      else $error("Play flag disagrees with the held note count.");

   a_idle_index_reset: assert property (@(posedge clock) disable iff (reset)
      !playing_ff |-> (unset_ff && index_ff == '0))
      else $error("Play index not reset while play is stopped.");

   a_divide_has_notes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (playing_ff && count_ff != '0))
      else $error("Step in progress with no held notes.");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("Remainder finished outside a step.");

endmodule
